### rtl/uart_8n1_transceiver_assert.svh
// ---------------------------------------------------------------------------
// UART 8N1 transceiver assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UART_8N1_TRANSCEIVER_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_ASSERT_SVH

// same-cycle implication
`define U8T_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8t assertion failed");

// next-cycle implication
`define U8T_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8t assertion failed");

`endif

### rtl/u8t_pkg.sv
// ---------------------------------------------------------------------------
// UART 8N1 transceiver package
// Phase and status codes, field widths and the result structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8t_pkg;

    localparam int PERIOD_W = 20;
    localparam int WAIT_W   = 21;
    localparam int TMO_FIELD_W = 24;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd868;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 20'd2;

    typedef logic [3:0] phase_t;
    localparam phase_t PH_IDLE  = 4'd0;
    localparam phase_t PH_START = 4'd1;
    localparam phase_t PH_DATA0 = 4'd2;
    localparam phase_t PH_STOP  = 4'd10;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FRAME   = 2'd1;
    localparam status_t ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_res_t;

    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] data;
        status_t    status;
    } rx_res_t;

endpackage

### rtl/uart_8n1_transceiver.sv
// ---------------------------------------------------------------------------
// UART 8N1 transceiver
// Bit-timed transmitter and receiver; every input word is one bit-clock tick.
//
//  port      dir  payload
//  s_*       in   tick word: tx request, rx arm, rx timeout, rx line level
//  m_*       out  tick result: tx line, busy flags, rx byte and status
//  cfg_*     in   bit_period register write
//
// One word per cycle sustained while m_tready is high. A word is registered,
// advanced through the tx and rx logic and its result registered.
// Back-pressure on m_tready holds the result and then the input register.
// Reset clears both state machines, bit_period returns to 868; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_8n1_transceiver
#(
    parameter int TIMEOUT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tx_start, tx_byte[7:0], rx_arm, rx_timeout[23:0], rx_level, zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_line, tx_busy, rx_busy, rx_valid, rx_byte[7:0], rx_status[1:0], pad
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);

    localparam int TMO_W = (TIMEOUT_BITS < u8t_pkg::TMO_FIELD_W) ? TIMEOUT_BITS
                                                                 : u8t_pkg::TMO_FIELD_W;
    localparam int RX_TIMER_W = (TMO_W > u8t_pkg::WAIT_W) ? TMO_W : u8t_pkg::WAIT_W;

    logic                          in_valid_reg, in_valid_next;
    logic [39:0]                   in_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [15:0]                   out_data_reg;
    logic [u8t_pkg::PERIOD_W-1:0]  period_reg;
    logic [u8t_pkg::PERIOD_W-1:0]  period_eff;
    logic                          step;
    logic                          s_accept;
    logic [TMO_W-1:0]              tmo_masked;
    u8t_pkg::tx_res_t              tx_res;
    u8t_pkg::rx_res_t              rx_res;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign period_eff = (period_reg < u8t_pkg::PERIOD_MIN) ? u8t_pkg::PERIOD_MIN : period_reg;
    assign tmo_masked = in_data_reg[10 +: TMO_W];

    assign in_valid_next  = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    u8t_tx u_tx
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .period   (period_eff),
        .tx_start (in_data_reg[0]),
        .tx_byte  (in_data_reg[8:1]),
        .res      (tx_res)
    );

    u8t_rx #(.TIMER_W(RX_TIMER_W)) u_rx
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .period     (period_eff),
        .rx_arm     (in_data_reg[9]),
        .rx_timeout (RX_TIMER_W'(tmo_masked)),
        .rx_level   (in_data_reg[34]),
        .res        (rx_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= u8t_pkg::PERIOD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
        end
        if (step)
        begin
            out_data_reg <= {2'b00, rx_res.status, rx_res.data, rx_res.valid,
                             rx_res.busy, tx_res.busy, tx_res.line};
        end
    end

`include "uart_8n1_transceiver_assert.svh"

    `U8T_ASSERT_SAME(a_no_commit_on_stall, clk, rst_n, out_valid_reg && !m_tready, !step)
    `U8T_ASSERT_SAME(a_idle_line_high, clk, rst_n, out_valid_reg && !out_data_reg[1], out_data_reg[0])
    `U8T_ASSERT_SAME(a_valid_ends_rx, clk, rst_n, out_valid_reg && out_data_reg[3], !out_data_reg[2])
    `U8T_ASSERT_SAME(a_quiet_when_not_valid, clk, rst_n, out_valid_reg && !out_data_reg[3], out_data_reg[13:4] == 10'd0)

endmodule

### rtl/u8t_tx.sv
// ---------------------------------------------------------------------------
// UART 8N1 transmitter
// Start bit, eight data bits LSB first, stop bit; one tick per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8t_tx
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [u8t_pkg::PERIOD_W-1:0]  period,
    input  logic                          tx_start,
    input  logic [7:0]                    tx_byte,
    output u8t_pkg::tx_res_t              res
);

    u8t_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                    shift_reg, shift_next;
    logic [u8t_pkg::PERIOD_W-1:0]  timer_reg, timer_next;
    logic [3:0]                    bit_idx;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        timer_next = timer_reg;
        res.line   = 1'b1;
        res.busy   = 1'b0;
        bit_idx    = 4'd0;
        if ((phase_reg == u8t_pkg::PH_IDLE) && tx_start)
        begin
            phase_next = u8t_pkg::PH_START;
            shift_next = tx_byte;
            timer_next = '0;
        end
        if (phase_next != u8t_pkg::PH_IDLE)
        begin
            res.busy = 1'b1;
            bit_idx  = phase_next - u8t_pkg::PH_DATA0;
            if (phase_next == u8t_pkg::PH_START)
            begin
                res.line = 1'b0;
            end
            else if (phase_next == u8t_pkg::PH_STOP)
            begin
                res.line = 1'b1;
            end
            else
            begin
                res.line = shift_next[bit_idx[2:0]];
            end
            timer_next = timer_next + 1'b1;
            if (timer_next >= period)
            begin
                timer_next = '0;
                phase_next = (phase_next >= u8t_pkg::PH_STOP) ? u8t_pkg::PH_IDLE
                                                              : phase_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= u8t_pkg::PH_IDLE;
            shift_reg <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
        end
    end

endmodule

### rtl/u8t_rx.sv
// ---------------------------------------------------------------------------
// UART 8N1 receiver
// Armed start-edge wait with timeout, mid-bit sampling, stop-bit check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8t_rx
#(
    parameter int TIMER_W = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [u8t_pkg::PERIOD_W-1:0]  period,
    input  logic                          rx_arm,
    input  logic [TIMER_W-1:0]            rx_timeout,
    input  logic                          rx_level,
    output u8t_pkg::rx_res_t              res
);

    u8t_pkg::phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]           timer_reg, timer_next;
    logic [7:0]                   shift_reg, shift_next;
    logic                         prev_reg;
    logic [u8t_pkg::WAIT_W-1:0]   first_wait;
    logic [3:0]                   bit_idx;

    assign first_wait = {1'b0, period} + {2'b00, period[u8t_pkg::PERIOD_W-1:1]}
                        - u8t_pkg::WAIT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        res.valid  = 1'b0;
        res.data   = 8'd0;
        res.status = u8t_pkg::ST_OK;
        bit_idx    = phase_reg - u8t_pkg::PH_DATA0;
        if ((phase_reg == u8t_pkg::PH_IDLE) && rx_arm)
        begin
            phase_next = u8t_pkg::PH_START;
            timer_next = rx_timeout;
        end
        if (phase_next == u8t_pkg::PH_START)
        begin
            if (prev_reg && !rx_level)
            begin
                phase_next = u8t_pkg::PH_DATA0;
                shift_next = 8'd0;
                timer_next = TIMER_W'(first_wait);
            end
            else if (timer_next == '0)
            begin
                phase_next = u8t_pkg::PH_IDLE;
                res.valid  = 1'b1;
                res.status = u8t_pkg::ST_TIMEOUT;
            end
            else
            begin
                timer_next = timer_next - 1'b1;
            end
        end
        else if (phase_next != u8t_pkg::PH_IDLE)
        begin
            if (timer_next != '0)
            begin
                timer_next = timer_next - 1'b1;
            end
            else if (phase_next >= u8t_pkg::PH_STOP)
            begin
                res.valid = 1'b1;
                if (rx_level)
                begin
                    res.data = shift_next;
                end
                else
                begin
                    res.status = u8t_pkg::ST_FRAME;
                end
                phase_next = u8t_pkg::PH_IDLE;
                timer_next = '0;
            end
            else
            begin
                if (rx_level)
                begin
                    shift_next[bit_idx[2:0]] = 1'b1;
                end
                phase_next = phase_next + 1'b1;
                timer_next = TIMER_W'(period - 1'b1);
            end
        end
        res.busy = (phase_next != u8t_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= u8t_pkg::PH_IDLE;
            timer_reg <= '0;
            shift_reg <= '0;
            prev_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            prev_reg  <= rx_level;
        end
    end

endmodule
